// ===== sv/ip_literal_cidr_parser_unit_assert.svh =====
// Assertion macros for the address literal parser.
`ifndef IP_LITERAL_CIDR_PARSER_UNIT_ASSERT_SVH
`define IP_LITERAL_CIDR_PARSER_UNIT_ASSERT_SVH

// Check a condition at every clock edge out of reset.
`define ICP_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by a condition.
`define ICP_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ===== sv/icp_pkg.sv =====
// Types, constants and per-character parse functions of the address literal parser.
package icp_pkg;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_V4      = 2'd1;
  localparam logic [1:0] KIND_V6      = 2'd2;

  localparam logic REG_MAX_PREFIX_V4 = 1'b0;
  localparam logic REG_MAX_PREFIX_V6 = 1'b1;

  localparam logic [5:0] MAX_V4_RESET = 6'd30;
  localparam logic [7:0] MAX_V6_RESET = 8'd126;
  localparam logic [7:0] V4_BITS      = 8'd32;
  localparam logic [7:0] V6_BITS      = 8'd128;
  localparam logic [7:0] PREFIX_SAT   = 8'd255;
  localparam logic [4:0] NIB_NONE     = 5'd16;

  typedef enum logic [2:0] {
    MODE_NONE = 3'b001,
    MODE_V4   = 3'b010,
    MODE_V6   = 3'b100
  } mode_t;

  typedef struct packed {
    logic [7:0][15:0] groups;
    logic [3:0]       gcnt;
    logic             gap;
    logic [3:0]       gpos;
    logic [15:0]      dacc;
    logic [2:0]       dcnt;
    mode_t            mode;
    logic [7:0]       pacc;
    logic             err;
    logic             inpre;
    logic             pdig;
    logic [1:0]       crun;
  } ps_t;

  localparam ps_t PS_CLEAR = '{
    groups: '0, gcnt: '0, gap: 1'b0, gpos: '0, dacc: '0, dcnt: '0,
    mode: MODE_NONE, pacc: '0, err: 1'b0, inpre: 1'b0, pdig: 1'b0, crun: '0
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (is_digit(c)) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 8'd10;
    end else begin
      d = {3'b000, NIB_NONE};
    end
    return d[4:0];
  endfunction

  function automatic ps_t push_nibble(input ps_t s, input logic [3:0] nib);
    ps_t r;
    r = s;
    r.dacc = {s.dacc[11:0], nib};
    r.dcnt = 3'(s.dcnt + 3'd1);
    return r;
  endfunction

  function automatic ps_t store_octet(input ps_t s);
    ps_t r;
    logic [9:0] val;
    logic bad;
    r = s;
    val = 10'(s.dacc[11:8]) * 10'd100 + 10'(s.dacc[7:4]) * 10'd10 + 10'(s.dacc[3:0]);
    bad = (s.dcnt == 3'd0) || (s.dcnt > 3'd3) || (s.gcnt >= 4'd4) ||
          (s.dacc[11:8] > 4'd9) || (s.dacc[7:4] > 4'd9) || (s.dacc[3:0] > 4'd9);
    if (bad || val > 10'd255) begin
      r.err = 1'b1;
    end else begin
      r.groups[s.gcnt[2:0]] = {6'd0, val};
      r.gcnt = 4'(s.gcnt + 4'd1);
      r.dacc = '0;
      r.dcnt = '0;
    end
    return r;
  endfunction

  function automatic ps_t store_group(input ps_t s);
    ps_t r;
    r = s;
    if (s.gcnt >= 4'd8) begin
      r.err = 1'b1;
    end else begin
      r.groups[s.gcnt[2:0]] = s.dacc;
      r.gcnt = 4'(s.gcnt + 4'd1);
      r.dacc = '0;
      r.dcnt = '0;
    end
    return r;
  endfunction

  function automatic ps_t close_address(input ps_t s);
    ps_t r;
    r = s;
    if (!s.err) begin
      unique case (s.mode)
        MODE_V4: begin
          r = store_octet(s);
          if (!r.err && r.gcnt != 4'd4) begin
            r.err = 1'b1;
          end
        end
        MODE_V6: begin
          if (s.dcnt > 3'd0) begin
            r = store_group(s);
          end else if (s.crun != 2'd2) begin
            r.err = 1'b1;
          end
          if (!r.err && (r.gap ? (r.gcnt > 4'd7) : (r.gcnt != 4'd8))) begin
            r.err = 1'b1;
          end
        end
        default: begin
          r.err = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

  function automatic ps_t v6_char(input ps_t s, input logic [7:0] c);
    ps_t r;
    logic [4:0] nib;
    r = s;
    nib = hex_nibble(c);
    if (nib != NIB_NONE) begin
      if ((s.crun == 2'd1 && s.gcnt == 4'd0 && !s.gap) || s.dcnt >= 3'd4) begin
        r.err = 1'b1;
      end else begin
        r = push_nibble(s, nib[3:0]);
        r.crun = 2'd0;
      end
    end else if (c == CH_COLON) begin
      if (s.dcnt > 3'd0) begin
        r = store_group(s);
        r.crun = 2'd1;
      end else if (s.crun == 2'd1) begin
        if (s.gap) begin
          r.err = 1'b1;
        end else begin
          r.gap = 1'b1;
          r.gpos = s.gcnt;
          r.crun = 2'd2;
        end
      end else if (s.crun == 2'd0) begin
        r.crun = 2'd1;
      end else begin
        r.err = 1'b1;
      end
    end else begin
      r.err = 1'b1;
    end
    return r;
  endfunction

  function automatic ps_t take_char(input ps_t s, input logic [7:0] c);
    ps_t r;
    logic [4:0] nib;
    logic [11:0] v;
    r = s;
    nib = hex_nibble(c);
    v = 12'(s.pacc) * 12'd10 + 12'(nib[3:0]);
    if (s.err) begin
      r = s;
    end else if (s.inpre) begin
      if (is_digit(c)) begin
        r.pacc = (v > 12'(PREFIX_SAT)) ? PREFIX_SAT : v[7:0];
        r.pdig = 1'b1;
      end else begin
        r.err = 1'b1;
      end
    end else if (c == CH_SLASH) begin
      r = close_address(s);
      r.inpre = 1'b1;
    end else begin
      unique case (s.mode)
        MODE_NONE: begin
          if (c == CH_DOT) begin
            r.mode = MODE_V4;
            r = store_octet(r);
          end else if (c == CH_COLON) begin
            r.mode = MODE_V6;
            r = v6_char(r, c);
          end else if (nib != NIB_NONE && s.dcnt < 3'd4) begin
            r = push_nibble(s, nib[3:0]);
          end else begin
            r.err = 1'b1;
          end
        end
        MODE_V4: begin
          if (is_digit(c)) begin
            if (s.dcnt >= 3'd3) begin
              r.err = 1'b1;
            end else begin
              r = push_nibble(s, nib[3:0]);
            end
          end else if (c == CH_DOT) begin
            if (s.gcnt >= 4'd3) begin
              r.err = 1'b1;
            end else begin
              r = store_octet(s);
            end
          end else begin
            r.err = 1'b1;
          end
        end
        MODE_V6: begin
          r = v6_char(s, c);
        end
        default: begin
          r.err = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ===== sv/ip_literal_cidr_parser_unit.sv =====
// Address literal and CIDR parser: per-character parse, end snapshot and result register.
//
// Takes an IPv4 or IPv6 address literal, optionally followed by /n, one
// character per item and at a sustained rate of one item per clock cycle.
// The character passes an input register, then updates the parse state; the
// item flagged end_of_text also copies the closed parse state into a
// snapshot register, from which gap expansion and network masking load the
// result register. Only the last character of a literal can be held up by a
// stalled result, and only once both the result and snapshot registers are
// full. The prefix limits max_prefix_v4 (index 0) and max_prefix_v6
// (index 1) reset to 30 and 126; the user must write them only while the
// block is idle, and the block itself does not enforce this.
`include "ip_literal_cidr_parser_unit_assert.svh"

module ip_literal_cidr_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic        has_prefix,
  output logic [7:0]  prefix_len,
  output logic [63:0] addr_hi,
  output logic [63:0] addr_lo,
  output logic [63:0] first_hi,
  output logic [63:0] first_lo,
  output logic [63:0] last_hi,
  output logic [63:0] last_lo
);

  logic [5:0]  max_v4;
  logic [7:0]  max_v6;

  logic        in_q_valid;
  logic [7:0]  in_q_char;
  logic        in_q_eot;

  icp_pkg::ps_t ps;
  icp_pkg::ps_t ps_next;
  icp_pkg::ps_t snap;
  icp_pkg::ps_t snap_next;
  logic         snap_valid;

  logic        out_move;
  logic        snap_ready;
  logic        pfire;
  logic        in_take;

  logic [7:0][15:0] g;
  logic [7:0]   lim;
  logic         bad;
  logic [127:0] addr;
  logic [127:0] host;
  logic [1:0]   kind_next;

  assign out_move   = !out_valid || !out_stall;
  assign snap_ready = !snap_valid || out_move;
  assign pfire      = in_q_valid && (!in_q_eot || snap_ready);
  assign in_stall   = in_q_valid && !pfire;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_v4 <= icp_pkg::MAX_V4_RESET;
      max_v6 <= icp_pkg::MAX_V6_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        icp_pkg::REG_MAX_PREFIX_V4: max_v4 <= cfg_data[5:0];
        icp_pkg::REG_MAX_PREFIX_V6: max_v6 <= cfg_data;
        default: max_v6 <= max_v6;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (pfire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_char <= char_in;
      in_q_eot  <= end_of_text;
    end
  end

  always_comb begin
    ps_next   = icp_pkg::take_char(ps, in_q_char);
    snap_next = ps_next.inpre ? ps_next : icp_pkg::close_address(ps_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ps <= icp_pkg::PS_CLEAR;
    end else if (pfire) begin
      ps <= in_q_eot ? icp_pkg::PS_CLEAR : ps_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (pfire && in_q_eot) begin
      snap_valid <= 1'b1;
    end else if (out_move) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pfire && in_q_eot) begin
      snap <= snap_next;
    end
  end

  always_comb begin
    logic [3:0] gp;
    logic [3:0] after;
    gp = {1'b0, snap.gpos[2:0]};
    if (gp > snap.gcnt) begin
      gp = snap.gcnt;
    end
    after = 4'(snap.gcnt - gp);
    for (int j = 0; j < 8; j++) begin
      logic [3:0] idx;
      idx = 4'(snap.gcnt + 4'(j));
      if (!snap.gap || 4'(j) < gp) begin
        g[j] = snap.groups[j];
      end else if (5'(4'(j)) + 5'(after) >= 5'd8) begin
        g[j] = snap.groups[idx[2:0]];
      end else begin
        g[j] = '0;
      end
    end
  end

  always_comb begin
    if (snap.mode == icp_pkg::MODE_V4) begin
      lim = ({2'b00, max_v4} > icp_pkg::V4_BITS) ? icp_pkg::V4_BITS : {2'b00, max_v4};
    end else begin
      lim = (max_v6 > icp_pkg::V6_BITS) ? icp_pkg::V6_BITS : max_v6;
    end
    bad = snap.err ||
          (snap.inpre && (!snap.pdig || snap.pacc == 8'd0 || snap.pacc > lim));
    if (snap.mode == icp_pkg::MODE_V4) begin
      kind_next = icp_pkg::KIND_V4;
      addr = {96'd0, snap.groups[0][7:0], snap.groups[1][7:0],
              snap.groups[2][7:0], snap.groups[3][7:0]};
      host = snap.inpre ? {96'd0, ({32{1'b1}} >> snap.pacc)} : '0;
    end else begin
      kind_next = icp_pkg::KIND_V6;
      addr = {g[0], g[1], g[2], g[3], g[4], g[5], g[6], g[7]};
      host = snap.inpre ? ({128{1'b1}} >> snap.pacc) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_move) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move && snap_valid) begin
      if (bad) begin
        kind       <= icp_pkg::KIND_INVALID;
        has_prefix <= 1'b0;
        prefix_len <= '0;
        addr_hi    <= '0;
        addr_lo    <= '0;
        first_hi   <= '0;
        first_lo   <= '0;
        last_hi    <= '0;
        last_lo    <= '0;
      end else begin
        kind       <= kind_next;
        has_prefix <= snap.inpre;
        prefix_len <= snap.inpre ? snap.pacc : 8'd0;
        addr_hi    <= addr[127:64];
        addr_lo    <= addr[63:0];
        first_hi   <= addr[127:64] & ~host[127:64];
        first_lo   <= addr[63:0] & ~host[63:0];
        last_hi    <= addr[127:64] | host[127:64];
        last_lo    <= addr[63:0] | host[63:0];
      end
    end
  end

  `ICP_ASSERT_HOLDS(a_gcnt_range, ps.gcnt <= 4'd8, "group count beyond eight")
  `ICP_ASSERT_HOLDS(a_snap_mode, !snap_valid || snap.err || snap.mode == icp_pkg::MODE_V4 || snap.mode == icp_pkg::MODE_V6, "clean snapshot without address family")
  `ICP_ASSERT_NEXT(a_eot_snap, pfire && in_q_eot, snap_valid && ps == icp_pkg::PS_CLEAR, "last character did not close the literal")
  `ICP_ASSERT_HOLDS(a_invalid_zero, !out_valid || kind != icp_pkg::KIND_INVALID || (!has_prefix && addr_hi == 64'd0 && addr_lo == 64'd0 && last_lo == 64'd0), "invalid result carries data")
  `ICP_ASSERT_HOLDS(a_v4_low, !out_valid || kind != icp_pkg::KIND_V4 || (addr_hi == 64'd0 && last_hi == 64'd0 && last_lo[63:32] == 32'd0), "IPv4 result above bit 31")

endmodule

// ===== tb/sv/ip_literal_cidr_parser_unit_tb.sv =====
// Self-checking testbench for the address literal and CIDR parser: table, random literals.
`timescale 1ns / 100ps

module ip_literal_cidr_parser_unit_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int NROWS        = 29;
  localparam int NPHASES      = 8;
  localparam int PHASE_CHARS  = 115;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 8;

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic [1:0]  kind;
    logic        has_prefix;
    logic [7:0]  prefix_len;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] first_hi;
    logic [63:0] first_lo;
    logic [63:0] last_hi;
    logic [63:0] last_lo;
  } lit_result_t;

  typedef struct {
    string       text;
    bit          typed;
    lit_result_t res;
  } dir_row_t;

  localparam lit_result_t RES_INVALID = '0;
  localparam lit_result_t V4_ZERO = '{icp_pkg::KIND_V4, 1'b0, 8'd0, 64'd0, 64'd0, 64'd0,
                                      64'd0, 64'd0, 64'd0};
  localparam lit_result_t V4_ONES = '{icp_pkg::KIND_V4, 1'b0, 8'd0, 64'd0, 64'hFFFF_FFFF,
                                      64'd0, 64'hFFFF_FFFF, 64'd0, 64'hFFFF_FFFF};
  localparam lit_result_t V6_ZERO = '{icp_pkg::KIND_V6, 1'b0, 8'd0, 64'd0, 64'd0, 64'd0,
                                      64'd0, 64'd0, 64'd0};
  localparam lit_result_t V6_ONES = '{icp_pkg::KIND_V6, 1'b0, 8'd0, '1, '1, '1, '1, '1, '1};

  // "~" stands for a NUL character
  dir_row_t dir_rows [NROWS] = '{
    '{"0.0.0.0", 1'b1, V4_ZERO},
    '{"255.255.255.255", 1'b1, V4_ONES},
    '{"192.168.001.77/24", 1'b0, '0},
    '{"10.0.0.1/30", 1'b0, '0},
    '{"10.0.0.1/31", 1'b1, RES_INVALID},
    '{"256.0.0.1", 1'b1, RES_INVALID},
    '{"1.2.3", 1'b1, RES_INVALID},
    '{"1.2.3.4.5", 1'b1, RES_INVALID},
    '{"1234.1.1.1", 1'b1, RES_INVALID},
    '{"1a.2.3.4", 1'b1, RES_INVALID},
    '{"1.2.3.4/", 1'b1, RES_INVALID},
    '{"1.2.3.4/0", 1'b1, RES_INVALID},
    '{"1.2.3.4/99999", 1'b1, RES_INVALID},
    '{"1.2.3.4/8/8", 1'b1, RES_INVALID},
    '{"1~.2.3.4", 1'b1, RES_INVALID},
    '{"beef", 1'b1, RES_INVALID},
    '{"::", 1'b1, V6_ZERO},
    '{"ffff:FFFF:ffff:ffff:ffff:ffff:ffff:FFFF", 1'b1, V6_ONES},
    '{"2001:db8::ff00:42:8329/126", 1'b0, '0},
    '{"fe80::/10", 1'b0, '0},
    '{":1:2:3:4:5:6:7", 1'b1, RES_INVALID},
    '{"1:2:3:4:5:6:7:", 1'b1, RES_INVALID},
    '{"1::2::3", 1'b1, RES_INVALID},
    '{":::", 1'b1, RES_INVALID},
    '{"1:2:3:4:5:6:7:8:9", 1'b1, RES_INVALID},
    '{"1:2:3:4:5:6:7", 1'b1, RES_INVALID},
    '{"1::2:3:4:5:6:7:8", 1'b1, RES_INVALID},
    '{"1:2::3.4", 1'b1, RES_INVALID},
    '{"::/127", 1'b1, RES_INVALID}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = icp_pkg::REG_MAX_PREFIX_V4;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_in = 8'd0;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [1:0]  kind;
  logic        has_prefix;
  logic [7:0]  prefix_len;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic [63:0] first_hi;
  logic [63:0] first_lo;
  logic [63:0] last_hi;
  logic [63:0] last_lo;

  ip_literal_cidr_parser_unit DUT (.*);

  always #10 clk = ~clk;

  lit_result_t pending_results[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          phase_chars = 0;
  bit          src_idles = 1'b1;
  bit          sink_idles = 1'b1;
  bit          long_hold_req = 1'b0;

  // parse state of the predictor
  logic [5:0]  lim_v4 = icp_pkg::MAX_V4_RESET;
  logic [7:0]  lim_v6 = icp_pkg::MAX_V6_RESET;
  logic [15:0] grp_store [8];
  int unsigned ngrp, gap_at, ndig, colons, pval;
  logic [15:0] acc;
  bit          gap_on, err, in_pre, pre_dig;
  icp_pkg::mode_t mode;

  function automatic void clear_parse_state();
    for (int i = 0; i < 8; i++) grp_store[i] = 16'd0;
    ngrp = 0;
    gap_at = 0;
    ndig = 0;
    colons = 0;
    pval = 0;
    acc = 16'd0;
    gap_on = 1'b0;
    err = 1'b0;
    in_pre = 1'b0;
    pre_dig = 1'b0;
    mode = icp_pkg::MODE_NONE;
  endfunction

  function automatic int unsigned nibble_of(input logic [7:0] c);
    if (c >= icp_pkg::CH_ZERO && c <= icp_pkg::CH_NINE) return c - icp_pkg::CH_ZERO;
    if (c >= icp_pkg::CH_LA && c <= icp_pkg::CH_LF) return c - icp_pkg::CH_LA + 10;
    if (c >= icp_pkg::CH_UA && c <= icp_pkg::CH_UF) return c - icp_pkg::CH_UA + 10;
    return 16;
  endfunction

  function automatic void push_digit(input int unsigned nib);
    acc = {acc[11:0], nib[3:0]};
    ndig++;
  endfunction

  function automatic void close_octet();
    int unsigned val, nib, i;
    val = 0;
    if (ndig == 0 || ndig > 3 || ngrp >= 4) begin
      err = 1'b1;
      return;
    end
    for (i = ndig; i > 0; i--) begin
      nib = (acc >> (4 * (i - 1))) & 4'hF;
      if (nib > 9) begin
        err = 1'b1;
        return;
      end
      val = val * 10 + nib;
    end
    if (val > 255) begin
      err = 1'b1;
      return;
    end
    grp_store[ngrp] = 16'(val);
    ngrp++;
    acc = 16'd0;
    ndig = 0;
  endfunction

  function automatic void close_group();
    if (ngrp >= 8) begin
      err = 1'b1;
      return;
    end
    grp_store[ngrp] = acc;
    ngrp++;
    acc = 16'd0;
    ndig = 0;
  endfunction

  function automatic void finish_address();
    if (err) return;
    case (mode)
      icp_pkg::MODE_V4: begin
        close_octet();
        if (!err && ngrp != 4) err = 1'b1;
      end
      icp_pkg::MODE_V6: begin
        if (ndig > 0) close_group();
        else if (colons != 2) err = 1'b1;
        if (!err && (gap_on ? (ngrp > 7) : (ngrp != 8))) err = 1'b1;
      end
      default: err = 1'b1;
    endcase
  endfunction

  function automatic void take_v6_char(input logic [7:0] c);
    int unsigned nib;
    nib = nibble_of(c);
    if (nib < 16) begin
      if ((colons == 1 && ngrp == 0 && !gap_on) || ndig >= 4) begin
        err = 1'b1;
      end else begin
        push_digit(nib);
        colons = 0;
      end
    end else if (c == icp_pkg::CH_COLON) begin
      if (ndig > 0) begin
        close_group();
        colons = 1;
      end else if (colons == 1) begin
        if (gap_on) begin
          err = 1'b1;
        end else begin
          gap_on = 1'b1;
          gap_at = ngrp;
          colons = 2;
        end
      end else if (colons == 0) begin
        colons = 1;
      end else begin
        err = 1'b1;
      end
    end else begin
      err = 1'b1;
    end
  endfunction

  // Advance the parse by one character; on the last one, build the result.
  function automatic bit advance_parse(input logic [7:0] c, input bit last,
                                       output lit_result_t res);
    int unsigned nib, lim, after, i;
    logic [15:0] g [8];
    logic [63:0] ahi, alo, hhi, hlo;
    bit digit;
    res = '0;
    nib = nibble_of(c);
    digit = (c >= icp_pkg::CH_ZERO && c <= icp_pkg::CH_NINE);
    if (err) begin
    end else if (in_pre) begin
      if (digit) begin
        pval = pval * 10 + nib;
        if (pval > 255) pval = 255;
        pre_dig = 1'b1;
      end else begin
        err = 1'b1;
      end
    end else if (c == icp_pkg::CH_SLASH) begin
      finish_address();
      in_pre = 1'b1;
    end else begin
      case (mode)
        icp_pkg::MODE_NONE: begin
          if (c == icp_pkg::CH_DOT) begin
            mode = icp_pkg::MODE_V4;
            close_octet();
          end else if (c == icp_pkg::CH_COLON) begin
            mode = icp_pkg::MODE_V6;
            take_v6_char(c);
          end else if (nib < 16 && ndig < 4) begin
            push_digit(nib);
          end else begin
            err = 1'b1;
          end
        end
        icp_pkg::MODE_V4: begin
          if (digit) begin
            if (ndig >= 3) err = 1'b1;
            else push_digit(nib);
          end else if (c == icp_pkg::CH_DOT) begin
            if (ngrp >= 3) err = 1'b1;
            else close_octet();
          end else begin
            err = 1'b1;
          end
        end
        default: take_v6_char(c);
      endcase
    end
    if (!last) return 1'b0;

    if (!in_pre) finish_address();
    if (!err && in_pre) begin
      if (mode == icp_pkg::MODE_V4) lim = (lim_v4 < 32) ? lim_v4 : 32;
      else lim = (lim_v6 < 128) ? lim_v6 : 128;
      if (!pre_dig || pval < 1 || pval > lim) err = 1'b1;
    end
    if (!err) begin
      ahi = 64'd0;
      alo = 64'd0;
      hhi = 64'd0;
      hlo = 64'd0;
      if (mode == icp_pkg::MODE_V4) begin
        alo = {32'd0, grp_store[0][7:0], grp_store[1][7:0], grp_store[2][7:0],
               grp_store[3][7:0]};
        if (in_pre) hlo = {32'd0, 32'hFFFF_FFFF >> pval};
      end else begin
        for (i = 0; i < 8; i++) g[i] = gap_on ? 16'd0 : grp_store[i];
        if (gap_on) begin
          after = ngrp - gap_at;
          for (i = 0; i < gap_at; i++) g[i] = grp_store[i];
          for (i = 0; i < after; i++) g[8 - after + i] = grp_store[gap_at + i];
        end
        ahi = {g[0], g[1], g[2], g[3]};
        alo = {g[4], g[5], g[6], g[7]};
        if (in_pre) begin
          if (pval < 64) begin
            hhi = ~64'd0 >> pval;
            hlo = ~64'd0;
          end else if (pval < 128) begin
            hlo = ~64'd0 >> (pval - 64);
          end
        end
      end
      res = '{(mode == icp_pkg::MODE_V4) ? icp_pkg::KIND_V4 : icp_pkg::KIND_V6, in_pre,
              in_pre ? 8'(pval) : 8'd0,
              ahi, alo, ahi & ~hhi, alo & ~hlo, ahi | hhi, alo | hlo};
    end
    clear_parse_state();
    return 1'b1;
  endfunction

  function automatic int unsigned wait_draw(input bit idles);
    if (!idles) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
  endfunction

  function automatic char_q_t to_chars(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back((s[i] == "~") ? 8'h00 : s[i]);
    return q;
  endfunction

  function automatic string dec_text(input int unsigned v, input int unsigned width);
    string s;
    s = $sformatf("%0d", v);
    while (s.len() < width) s = {"0", s};
    return s;
  endfunction

  function automatic string prefix_text(input int unsigned top, input int unsigned full);
    case ($urandom_range(0, 6))
      0: return {"/", dec_text(top, 1)};
      1: return {"/", dec_text(top + 1, 1)};
      2: return "/0";
      3: return "/";
      4: return {"/", dec_text($urandom_range(100, 99999), 1)};
      default: return {"/", dec_text($urandom_range(1, full), $urandom_range(1, 3))};
    endcase
  endfunction

  // Mostly well-formed literals with random content, some broken, some noise.
  function automatic char_q_t random_literal();
    string syms, s, gtxt;
    char_q_t q;
    int unsigned pick, n, k, i, v, wid;
    bit gap;
    syms = "0123456789abcdefABCDEF.:/";
    s = "";
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++)
        q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                         : syms[$urandom_range(0, syms.len() - 1)]);
      return q;
    end
    if (pick % 2) begin
      for (i = 0; i < 4; i++) begin
        case ($urandom_range(0, 9))
          0: v = 0;
          1: v = 255;
          2: v = $urandom_range(256, 999);
          default: v = $urandom_range(0, 255);
        endcase
        s = {s, (i == 0) ? "" : ".", dec_text(v, $urandom_range(1, 3))};
      end
      if ($urandom_range(0, 1)) s = {s, prefix_text((lim_v4 < 32) ? lim_v4 : 32, 32)};
    end else begin
      gap = ($urandom_range(0, 2) != 0);
      n = gap ? $urandom_range(0, 7) : 8;
      if ($urandom_range(0, 9) == 0) n = gap ? 8 : $urandom_range(7, 9);
      k = gap ? $urandom_range(0, n) : n;
      for (i = 0; i < n; i++) begin
        if (gap && i == k) s = {s, "::"};
        else if (i > 0) s = {s, ":"};
        case ($urandom_range(0, 5))
          0: v = 0;
          1: v = 16'hFFFF;
          default: v = $urandom_range(0, 16'hFFFF);
        endcase
        gtxt = $sformatf("%0h", v);
        wid = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(gtxt.len(), 4);
        while (gtxt.len() < wid) gtxt = {"0", gtxt};
        if ($urandom_range(0, 1)) gtxt = gtxt.toupper();
        s = {s, gtxt};
      end
      if (gap && k == n) s = {s, "::"};
      if ($urandom_range(0, 1)) s = {s, prefix_text((lim_v6 < 128) ? lim_v6 : 128, 128)};
    end
    q = to_chars(s);
    if (pick >= 75) begin
      k = $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 2))
        0: q[k] = 8'($urandom_range(0, 255));
        1: if (q.size() > 1) q.delete(k);
        default: q.insert(k, syms[$urandom_range(0, syms.len() - 1)]);
      endcase
    end
    return q;
  endfunction

  task automatic send_literal(input char_q_t chars, input bit typed,
                              input lit_result_t fixed);
    lit_result_t res;
    int unsigned k, w;
    bit last;
    for (k = 0; k < chars.size(); k++) begin
      last = (k == chars.size() - 1);
      w = wait_draw(src_idles);
      repeat (w) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      @(negedge clk);
      in_valid <= 1'b1;
      char_in <= chars[k];
      end_of_text <= last;
      do @(posedge clk); while (in_stall);
      if (advance_parse(chars[k], last, res)) pending_results.push_back(typed ? fixed : res);
      phase_chars++;
    end
  endtask

  task automatic park_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limits(input logic [7:0] v4, input logic [7:0] v6);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= icp_pkg::REG_MAX_PREFIX_V4;
    cfg_data <= v4;
    @(negedge clk);
    cfg_index <= icp_pkg::REG_MAX_PREFIX_V6;
    cfg_data <= v6;
    @(negedge clk);
    cfg_write <= 1'b0;
    lim_v4 = v4[5:0];
    lim_v6 = v6;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned hold_left;
    lit_result_t want;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      out_stall <= (hold_left > 0);
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got kind %0d addr %h_%h",
                   $time, kind, addr_hi, addr_lo);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("kind", 64'(want.kind), 64'(kind));
          compare_field("has_prefix", 64'(want.has_prefix), 64'(has_prefix));
          compare_field("prefix_len", 64'(want.prefix_len), 64'(prefix_len));
          compare_field("addr_hi", want.addr_hi, addr_hi);
          compare_field("addr_lo", want.addr_lo, addr_lo);
          compare_field("first_hi", want.first_hi, first_hi);
          compare_field("first_lo", want.first_lo, first_lo);
          compare_field("last_hi", want.last_hi, last_hi);
          compare_field("last_lo", want.last_lo, last_lo);
        end
        hold_left = wait_draw(sink_idles);
      end else if (hold_left > 0) begin
        hold_left--;
      end
    end
  end

  initial begin : stimulus
    int ph;
    logic [7:0] v4_set, v6_set;
    clear_parse_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NROWS; i++)
      send_literal(to_chars(dir_rows[i].text), dir_rows[i].typed, dir_rows[i].res);
    park_input();
    drain();

    for (ph = 0; ph < NPHASES; ph++) begin
      case (ph)
        0: begin v4_set = 8'd0;   v6_set = 8'd0;   end
        1: begin v4_set = 8'hFF;  v6_set = 8'hFF;  end
        2: begin v4_set = 8'd32;  v6_set = 8'd128; end
        3: begin v4_set = 8'd1;   v6_set = 8'd1;   end
        default: begin
          v4_set = 8'($urandom_range(0, 255));
          v6_set = 8'($urandom_range(0, 255));
        end
      endcase
      set_limits(v4_set, v6_set);
      src_idles = (ph % 3 == 1);
      sink_idles = (ph % 3 != 0);
      if (ph == 2) long_hold_req = 1'b1;
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) send_literal(random_literal(), 1'b0, '0);
      park_input();
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
